// ----- rtl/core/ps2_mouse_cursor_tracker_unit_defines.svh -----
// assertion macros shared by the tracker rtl
`ifndef PS2_MOUSE_CURSOR_TRACKER_UNIT_DEFINES_SVH
`define PS2_MOUSE_CURSOR_TRACKER_UNIT_DEFINES_SVH

// same-cycle implication, sampled on clk, off during reset
`define PS2MCT_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, sampled on clk, off during reset
`define PS2MCT_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- rtl/core/ps2mct_pkg.sv -----
`timescale 1ns / 1ps

package ps2mct_pkg;

  localparam int COORD_BITS_DEF = 12;
  localparam int CFG_DATA_W     = 13;
  localparam int CFG_IDX_W      = 1;

  localparam logic [CFG_IDX_W-1:0] CFG_SCREEN_WIDTH  = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_SCREEN_HEIGHT = 1'b1;

  localparam logic [CFG_DATA_W-1:0] SCREEN_WIDTH_RST  = 13'd1024;
  localparam logic [CFG_DATA_W-1:0] SCREEN_HEIGHT_RST = 13'd768;

  localparam int POS_X_RST = 512;
  localparam int POS_Y_RST = 384;

  localparam int HDR_LEFT_BIT  = 0;
  localparam int HDR_RIGHT_BIT = 1;
  localparam int HDR_XSIGN_BIT = 4;
  localparam int HDR_YSIGN_BIT = 5;

  typedef enum logic [1:0] {
    POS_HEADER = 2'd0,
    POS_XMOVE  = 2'd1,
    POS_YMOVE  = 2'd2
  } byte_pos_t;

  typedef struct packed {
    logic [7:0] header;
    logic [7:0] x_move;
    logic [7:0] y_move;
  } pkt_t;

endpackage

// ----- rtl/core/ps2mct_in_if.sv -----
`timescale 1ns / 1ps

interface ps2mct_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       from_aux;

  modport source (output valid, output data_byte, output from_aux, input ready);
  modport sink (input valid, input data_byte, input from_aux, output ready);
endinterface

// ----- rtl/core/ps2mct_out_if.sv -----
`timescale 1ns / 1ps

interface ps2mct_out_if #(
  parameter int COORD_BITS = ps2mct_pkg::COORD_BITS_DEF
);
  logic                  valid;
  logic                  ready;
  logic [COORD_BITS-1:0] cursor_x;
  logic [COORD_BITS-1:0] cursor_y;
  logic                  left_button;
  logic                  right_button;

  modport source (
    output valid, output cursor_x, output cursor_y,
    output left_button, output right_button, input ready
  );
  modport sink (
    input valid, input cursor_x, input cursor_y,
    input left_button, input right_button, output ready
  );
endinterface

// ----- rtl/core/ps2mct_pkt.sv -----
`timescale 1ns / 1ps
`include "ps2_mouse_cursor_tracker_unit_defines.svh"

module ps2mct_pkt (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  input  logic [7:0]        in_data_byte,
  input  logic              in_from_aux,
  output ps2mct_pkg::pkt_t  pkt,
  output logic              pkt_valid,
  input  logic              pkt_ready
);
  import ps2mct_pkg::*;

  byte_pos_t  byte_pos_r, byte_pos_nxt;
  logic [7:0] header_r, header_nxt;
  logic [7:0] x_move_r, x_move_nxt;
  pkt_t       pkt_r, pkt_nxt;
  logic       pkt_vld_r, pkt_vld_nxt;
  logic       byte_acc;

  assign in_ready  = !pkt_vld_r || pkt_ready;
  assign byte_acc  = in_valid && in_ready && in_from_aux;
  assign pkt       = pkt_r;
  assign pkt_valid = pkt_vld_r;

  always_comb begin
    byte_pos_nxt = byte_pos_r;
    header_nxt   = header_r;
    x_move_nxt   = x_move_r;
    pkt_nxt      = pkt_r;
    pkt_vld_nxt  = pkt_vld_r && !pkt_ready;
    if (byte_acc) begin
      unique case (byte_pos_r)
        POS_HEADER: begin
          header_nxt   = in_data_byte;
          byte_pos_nxt = POS_XMOVE;
        end
        POS_XMOVE: begin
          x_move_nxt   = in_data_byte;
          byte_pos_nxt = POS_YMOVE;
        end
        default: begin
          pkt_nxt.header = header_r;
          pkt_nxt.x_move = x_move_r;
          pkt_nxt.y_move = in_data_byte;
          pkt_vld_nxt    = 1'b1;
          byte_pos_nxt   = POS_HEADER;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      byte_pos_r <= POS_HEADER;
      pkt_vld_r  <= 1'b0;
    end else begin
      byte_pos_r <= byte_pos_nxt;
      pkt_vld_r  <= pkt_vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    header_r <= header_nxt;
    x_move_r <= x_move_nxt;
    pkt_r    <= pkt_nxt;
  end

  // third byte of a packet always produces a packet
  `PS2MCT_ASSERT_NEXT(a_third_byte_pkt, byte_acc && byte_pos_r == POS_YMOVE, pkt_vld_r, "third byte lost")
  // ignored bytes leave the framing alone
  `PS2MCT_ASSERT_NEXT(a_aux_ignored, in_valid && in_ready && !in_from_aux, $stable(byte_pos_r), "non-aux byte moved framing")
  // a waiting packet is not overwritten
  `PS2MCT_ASSERT_NEXT(a_pkt_hold, pkt_vld_r && !pkt_ready, pkt_vld_r && $stable(pkt_r), "pending packet changed")

endmodule

// ----- rtl/core/ps2mct_cursor.sv -----
`timescale 1ns / 1ps
`include "ps2_mouse_cursor_tracker_unit_defines.svh"

module ps2mct_cursor #(
  parameter int COORD_BITS = ps2mct_pkg::COORD_BITS_DEF
) (
  input  logic                                  clk,
  input  logic                                  rst_n,
  input  logic                                  cfg_wr_en,
  input  logic [ps2mct_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [ps2mct_pkg::CFG_DATA_W-1:0]     cfg_data,
  input  ps2mct_pkg::pkt_t                      pkt,
  input  logic                                  pkt_valid,
  output logic                                  pkt_ready,
  output logic                                  out_valid,
  input  logic                                  out_ready,
  output logic [COORD_BITS-1:0]                 cursor_x,
  output logic [COORD_BITS-1:0]                 cursor_y,
  output logic                                  left_button,
  output logic                                  right_button
);
  import ps2mct_pkg::*;

  localparam int SW = COORD_BITS + 2;
  localparam int LW = (COORD_BITS + 1 > CFG_DATA_W) ? COORD_BITS + 1 : CFG_DATA_W;
  localparam int COORD_MAX = (2 ** COORD_BITS) - 1;
  localparam logic [LW-1:0] FULL_SIZE = LW'(2 ** COORD_BITS);
  localparam logic [COORD_BITS-1:0] RST_X =
    COORD_BITS'((POS_X_RST > COORD_MAX) ? COORD_MAX : POS_X_RST);
  localparam logic [COORD_BITS-1:0] RST_Y =
    COORD_BITS'((POS_Y_RST > COORD_MAX) ? COORD_MAX : POS_Y_RST);

  logic [CFG_DATA_W-1:0]  width_r, width_nxt;
  logic [CFG_DATA_W-1:0]  height_r, height_nxt;
  logic [COORD_BITS-1:0]  pos_x_r, pos_x_nxt;
  logic [COORD_BITS-1:0]  pos_y_r, pos_y_nxt;
  logic                   left_r, left_nxt;
  logic                   right_r, right_nxt;
  logic                   out_vld_r, out_vld_nxt;
  logic                   pkt_take;
  logic [COORD_BITS-1:0]  lim_x_m1, lim_y_m1;
  logic signed [8:0]      dx, dy;
  logic signed [SW-1:0]   sum_x, sum_y;

  function automatic logic [COORD_BITS-1:0] size_to_max(input logic [CFG_DATA_W-1:0] size);
    logic [LW-1:0] size_ext;
    size_ext = LW'(size);
    if (size == '0) begin
      size_to_max = '0;
    end else if (size_ext > FULL_SIZE) begin
      size_to_max = '1;
    end else begin
      size_to_max = COORD_BITS'(size_ext - LW'(1));
    end
  endfunction

  function automatic logic [COORD_BITS-1:0] clamp_axis(
    input logic signed [SW-1:0] v,
    input logic [COORD_BITS-1:0] lim_m1
  );
    if (v < 0) begin
      clamp_axis = '0;
    end else if (v > $signed({2'b00, lim_m1})) begin
      clamp_axis = lim_m1;
    end else begin
      clamp_axis = COORD_BITS'(v);
    end
  endfunction

  assign pkt_ready = !out_vld_r || out_ready;
  assign pkt_take  = pkt_valid && pkt_ready;

  assign lim_x_m1 = size_to_max(width_r);
  assign lim_y_m1 = size_to_max(height_r);
  assign dx       = {pkt.header[HDR_XSIGN_BIT], pkt.x_move};
  assign dy       = {pkt.header[HDR_YSIGN_BIT], pkt.y_move};
  assign sum_x    = $signed({2'b00, pos_x_r}) + SW'(dx);
  assign sum_y    = $signed({2'b00, pos_y_r}) - SW'(dy);

  always_comb begin
    width_nxt  = width_r;
    height_nxt = height_r;
    if (cfg_wr_en) begin
      unique case (cfg_index)
        CFG_SCREEN_WIDTH:  width_nxt  = cfg_data;
        CFG_SCREEN_HEIGHT: height_nxt = cfg_data;
        default: ;
      endcase
    end
  end

  always_comb begin
    pos_x_nxt   = pos_x_r;
    pos_y_nxt   = pos_y_r;
    left_nxt    = left_r;
    right_nxt   = right_r;
    out_vld_nxt = out_vld_r && !out_ready;
    if (pkt_take) begin
      pos_x_nxt   = clamp_axis(sum_x, lim_x_m1);
      pos_y_nxt   = clamp_axis(sum_y, lim_y_m1);
      left_nxt    = pkt.header[HDR_LEFT_BIT];
      right_nxt   = pkt.header[HDR_RIGHT_BIT];
      out_vld_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      width_r   <= SCREEN_WIDTH_RST;
      height_r  <= SCREEN_HEIGHT_RST;
      pos_x_r   <= RST_X;
      pos_y_r   <= RST_Y;
      out_vld_r <= 1'b0;
    end else begin
      width_r   <= width_nxt;
      height_r  <= height_nxt;
      pos_x_r   <= pos_x_nxt;
      pos_y_r   <= pos_y_nxt;
      out_vld_r <= out_vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    left_r  <= left_nxt;
    right_r <= right_nxt;
  end

  assign out_valid    = out_vld_r;
  assign cursor_x     = pos_x_r;
  assign cursor_y     = pos_y_r;
  assign left_button  = left_r;
  assign right_button = right_r;

  `PS2MCT_ASSERT_NEXT(a_take_gives_item, pkt_take, out_vld_r, "packet taken without result")
  // cursor cannot move under a stalled result
  `PS2MCT_ASSERT_NEXT(a_stall_pos, out_vld_r && !out_ready, $stable(pos_x_r) && $stable(pos_y_r), "cursor moved while result stalled")
  `PS2MCT_ASSERT_NEXT(a_clamp_x, pkt_take, pos_x_r <= $past(lim_x_m1) && pos_y_r <= $past(lim_y_m1), "cursor outside screen")

endmodule

// ----- rtl/core/ps2_mouse_cursor_tracker_unit.sv -----
`timescale 1ns / 1ps

// PS/2 mouse cursor tracker. Accepts one controller byte per cycle; bytes whose aux flag is
// clear are dropped. Every third aux byte closes a 3-byte packet that is held in a packet
// register; when the cursor stage takes it, the cursor update (9-bit signed moves, Y
// inverted, clamp to the configured screen) lands in the result register. The packet
// register and the result register each free up as soon as the stage after them takes
// their contents, which keeps input at one byte per cycle; only a stalled result that
// meets a completed packet holds off the input. The user must write the screen size
// registers (index 0 width, 1 height) through the cfg port only while idle; not enforced.
module ps2_mouse_cursor_tracker_unit #(
  parameter int COORD_BITS = ps2mct_pkg::COORD_BITS_DEF
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               cfg_wr_en,
  input  logic [ps2mct_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [ps2mct_pkg::CFG_DATA_W-1:0]  cfg_data,
  ps2mct_in_if.sink                          in_ch,
  ps2mct_out_if.source                       out_ch
);
  import ps2mct_pkg::*;

  pkt_t pkt;
  logic pkt_valid;
  logic pkt_ready;

  ps2mct_pkt u_pkt (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_ch.valid),
    .in_ready     (in_ch.ready),
    .in_data_byte (in_ch.data_byte),
    .in_from_aux  (in_ch.from_aux),
    .pkt          (pkt),
    .pkt_valid    (pkt_valid),
    .pkt_ready    (pkt_ready)
  );

  ps2mct_cursor #(
    .COORD_BITS (COORD_BITS)
  ) u_cursor (
    .clk          (clk),
    .rst_n        (rst_n),
    .cfg_wr_en    (cfg_wr_en),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .pkt          (pkt),
    .pkt_valid    (pkt_valid),
    .pkt_ready    (pkt_ready),
    .out_valid    (out_ch.valid),
    .out_ready    (out_ch.ready),
    .cursor_x     (out_ch.cursor_x),
    .cursor_y     (out_ch.cursor_y),
    .left_button  (out_ch.left_button),
    .right_button (out_ch.right_button)
  );

endmodule

// ----- tb/testbench.sv -----
`timescale 1ns / 1ps

module testbench;
  import ps2mct_pkg::*;

  localparam int COORD_W   = COORD_BITS_DEF;
  localparam int CYC_LIMIT = 400000;
  localparam int N_PHASES  = 9;
  localparam int RAND_PER_PHASE = 111;

  typedef struct {
    logic [7:0] data;
    logic       aux;
    bit         drain;
  } ctl_byte_t;

  typedef struct {
    logic [COORD_W-1:0] cx;
    logic [COORD_W-1:0] cy;
    logic               lb;
    logic               rb;
  } cursor_rpt_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic cfg_wr_en = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = CFG_SCREEN_WIDTH;
  logic [CFG_DATA_W-1:0] cfg_data = '0;

  ps2mct_in_if in_ch ();
  ps2mct_out_if #(.COORD_BITS(COORD_W)) out_ch ();

  ps2_mouse_cursor_tracker_unit #(.COORD_BITS(COORD_W)) dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_wr_en (cfg_wr_en),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .in_ch     (in_ch),
    .out_ch    (out_ch)
  );

  ctl_byte_t   pending_bytes[$];
  cursor_rpt_t expected_cursor[$];

  bit quiet = 1'b0;
  int fails = 0;
  int bytes_sent = 0;
  int reports_checked = 0;
  int cyc = 0;

  // tracker state kept by the checker
  logic [1:0]         trk_pos;
  logic [7:0]         trk_hdr;
  logic [7:0]         trk_xmv;
  logic [COORD_W-1:0] trk_x;
  logic [COORD_W-1:0] trk_y;
  logic [12:0]        trk_w;
  logic [12:0]        trk_h;

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  initial begin
    in_ch.valid = 1'b0;
    in_ch.data_byte = 8'h00;
    in_ch.from_aux = 1'b0;
    out_ch.ready = 1'b0;
  end

  function automatic logic [COORD_W-1:0] clamp_to_screen(int v, logic [12:0] size);
    int lim;
    lim = int'(size);
    if (lim < 1) lim = 1;
    if (lim > (1 << COORD_W)) lim = 1 << COORD_W;
    if (v < 0) v = 0;
    if (v > lim - 1) v = lim - 1;
    return v[COORD_W-1:0];
  endfunction

  task automatic advance_tracker(input logic [7:0] b);
    int dx;
    int dy;
    cursor_rpt_t r;
    if (trk_pos == POS_HEADER) begin
      trk_hdr = b;
      trk_pos = POS_XMOVE;
    end else if (trk_pos == POS_XMOVE) begin
      trk_xmv = b;
      trk_pos = POS_YMOVE;
    end else begin
      trk_pos = POS_HEADER;
      dx = int'(trk_xmv) - (trk_hdr[HDR_XSIGN_BIT] ? 256 : 0);
      dy = int'(b) - (trk_hdr[HDR_YSIGN_BIT] ? 256 : 0);
      trk_x = clamp_to_screen(int'(trk_x) + dx, trk_w);
      trk_y = clamp_to_screen(int'(trk_y) - dy, trk_h);
      r.cx = trk_x;
      r.cy = trk_y;
      r.lb = trk_hdr[HDR_LEFT_BIT];
      r.rb = trk_hdr[HDR_RIGHT_BIT];
      expected_cursor.push_back(r);
    end
  endtask

  // driver
  always @(posedge clk) begin
    ctl_byte_t nxt;
    if (!rst_n) begin
      in_ch.valid <= 1'b0;
      in_ch.data_byte <= 8'h00;
      in_ch.from_aux <= 1'b0;
    end else if (!in_ch.valid || in_ch.ready) begin
      if (pending_bytes.size() > 0 &&
          !(pending_bytes[0].drain && (in_ch.valid || expected_cursor.size() > 0)) &&
          (quiet || $urandom_range(99) >= 18)) begin
        nxt = pending_bytes.pop_front();
        in_ch.valid <= 1'b1;
        in_ch.data_byte <= nxt.data;
        in_ch.from_aux <= nxt.aux;
      end else begin
        in_ch.valid <= 1'b0;
      end
    end
  end

  always @(posedge clk) begin
    if (!rst_n) out_ch.ready <= 1'b0;
    else out_ch.ready <= quiet || ($urandom_range(99) >= 18);
  end

  // monitor and checker
  always @(posedge clk) begin
    cursor_rpt_t e;
    if (!rst_n) begin
      trk_pos = POS_HEADER;
      trk_hdr = 8'h00;
      trk_xmv = 8'h00;
      trk_x = COORD_W'(POS_X_RST);
      trk_y = COORD_W'(POS_Y_RST);
      trk_w = SCREEN_WIDTH_RST;
      trk_h = SCREEN_HEIGHT_RST;
    end else begin
      if (cfg_wr_en) begin
        if (cfg_index == CFG_SCREEN_WIDTH) trk_w = cfg_data;
        else trk_h = cfg_data;
      end
      if (in_ch.valid && in_ch.ready) begin
        bytes_sent++;
        if (in_ch.from_aux) advance_tracker(in_ch.data_byte);
      end
      if (out_ch.valid && out_ch.ready) begin
        if (expected_cursor.size() == 0) begin
          $error("cursor report with none expected: x=%0d y=%0d",
                 out_ch.cursor_x, out_ch.cursor_y);
          fails++;
        end else begin
          e = expected_cursor.pop_front();
          reports_checked++;
          if (out_ch.cursor_x !== e.cx) begin
            $error("cursor_x expected %0d got %0d", e.cx, out_ch.cursor_x);
            fails++;
          end
          if (out_ch.cursor_y !== e.cy) begin
            $error("cursor_y expected %0d got %0d", e.cy, out_ch.cursor_y);
            fails++;
          end
          if (out_ch.left_button !== e.lb) begin
            $error("left_button expected %0b got %0b", e.lb, out_ch.left_button);
            fails++;
          end
          if (out_ch.right_button !== e.rb) begin
            $error("right_button expected %0b got %0b", e.rb, out_ch.right_button);
            fails++;
          end
        end
      end
    end
  end

  always @(posedge clk) begin
    cyc++;
    if (cyc > CYC_LIMIT) begin
      $display("timeout after %0d cycles", cyc);
      $display("CHECK FAILED");
      $finish;
    end
  end

  task automatic queue_byte(input logic [7:0] b, input logic aux, input bit drain);
    ctl_byte_t c;
    c.data = b;
    c.aux = aux;
    c.drain = drain;
    pending_bytes.push_back(c);
  endtask

  task automatic queue_packet(input logic [7:0] h, input logic [7:0] x, input logic [7:0] y,
                              input bit drain);
    queue_byte(h, 1'b1, drain);
    queue_byte(x, 1'b1, 1'b0);
    queue_byte(y, 1'b1, 1'b0);
  endtask

  function automatic logic [7:0] pick_move();
    case ($urandom_range(7))
      0: return 8'h00;
      1: return 8'hFF;
      2: return 8'h80;
      3: return 8'h7F;
      default: return 8'($urandom_range(255));
    endcase
  endfunction

  task automatic wait_drained();
    do @(posedge clk);
    while (pending_bytes.size() > 0 || in_ch.valid || expected_cursor.size() > 0);
    repeat (8) @(posedge clk);
  endtask

  task automatic write_screen(input logic [12:0] w, input logic [12:0] h);
    @(posedge clk);
    cfg_wr_en <= 1'b1;
    cfg_index <= CFG_SCREEN_WIDTH;
    cfg_data <= w;
    @(posedge clk);
    cfg_index <= CFG_SCREEN_HEIGHT;
    cfg_data <= h;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
  endtask

  initial begin
    logic [12:0] ph_w[N_PHASES];
    logic [12:0] ph_h[N_PHASES];
    int n;
    int k;
    ph_w = '{13'd1024, 13'd4096, 13'd640, 13'd0, 13'd1, 13'd8191, 13'd4096, 13'h1555,
             13'h0AAA};
    ph_h = '{13'd768, 13'd4096, 13'd480, 13'd0, 13'd4096, 13'd4097, 13'd1, 13'h0AAA,
             13'h1555};
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;

    // directed: sign extremes, both buttons, ignored bytes mid-packet, clamps at edges
    queue_packet(8'h0B, 8'hFF, 8'hFF, 1'b0);
    queue_byte(8'h38, 1'b1, 1'b0);
    queue_byte(8'hFF, 1'b0, 1'b0);
    queue_byte(8'h00, 1'b0, 1'b0);
    queue_byte(8'h00, 1'b1, 1'b0);
    queue_byte(8'h00, 1'b1, 1'b0);
    queue_packet(8'h0A, 8'hFF, 8'h80, 1'b1);
    queue_packet(8'h09, 8'hFF, 8'hFF, 1'b0);
    queue_packet(8'h09, 8'hFF, 8'h7F, 1'b0);
    queue_packet(8'h38, 8'h00, 8'h00, 1'b0);
    queue_packet(8'hF8, 8'h00, 8'h00, 1'b0);

    for (int p = 0; p < N_PHASES; p++) begin
      if (p > 0) begin
        wait_drained();
        write_screen(ph_w[p], ph_h[p]);
      end
      quiet = (p == 1);
      n = 0;
      while (n < RAND_PER_PHASE) begin
        if ($urandom_range(9) == 0) begin
          queue_byte(8'($urandom_range(255)), 1'b0, 1'b0);
        end else begin
          queue_byte(8'($urandom_range(255)), 1'b1, $urandom_range(99) < 3);
          for (k = 0; k < 2; k++) begin
            if ($urandom_range(11) == 0) queue_byte(8'($urandom_range(255)), 1'b0, 1'b0);
            queue_byte(pick_move(), 1'b1, 1'b0);
          end
          n += 3;
        end
      end
    end

    wait_drained();
    repeat (12) @(posedge clk);
    if (expected_cursor.size() > 0) begin
      $error("%0d cursor reports never arrived", expected_cursor.size());
      fails++;
    end
    $display("sent %0d controller bytes over %0d screen sizes, checked %0d cursor reports",
             bytes_sent, N_PHASES, reports_checked);
    if (fails == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
